FILE: rtl/core/vwet_pkg.sv
// ----------------------------------------------------------------------------
// vwet_pkg
// Types and constants shared by the vertex weld / edge twin table.
// ----------------------------------------------------------------------------
package vwet_pkg;

  localparam int unsigned PointDepth = 1024;
  localparam int unsigned EdgeDepth  = 1024;
  localparam int unsigned PointAw    = $clog2(PointDepth);
  localparam int unsigned EdgeAw     = $clog2(EdgeDepth);
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] TolReset = 16'd25;

  typedef struct packed {
    logic        kind;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [15:0] face_id;
    logic        face_end;
  } in_item_t;

  typedef struct packed {
    logic [9:0] point_index;
    logic       edge_valid;
    logic [9:0] edge_index;
    logic       edge_shared;
    logic       table_full;
    logic       last;
  } out_item_t;

  // One edge job for the back part.
  typedef struct packed {
    logic              clear;
    logic [PointAw-1:0] p1;
    logic [PointAw-1:0] p2;
    logic [PointAw-1:0] pt;
    logic [15:0]       face;
    logic              pfull;
    logic              edge_valid;
    logic              last;
  } edge_job_t;

endpackage

FILE: rtl/core/vwet_front.sv
// ----------------------------------------------------------------------------
// vwet_front
// Welds vertices against the point table by linear scan and issues edge jobs.
// ----------------------------------------------------------------------------
module vwet_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         tol_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vwet_pkg::in_item_t  in_data_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output vwet_pkg::edge_job_t job_o
);

  localparam int unsigned Aw = vwet_pkg::PointAw;
  localparam int unsigned Cw = Aw + 1;
  localparam logic [Cw-1:0] Last = Cw'(vwet_pkg::PointDepth - 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_JOB1, S_JOB2} state_e;

  state_e             state_q;
  vwet_pkg::in_item_t item_q;
  logic [Cw-1:0]      count_q, scan_q;
  logic [Aw-1:0]      first_q, prev_q, p_q;
  logic               inside_q, pfull_q;
  logic [31:0]        mx [vwet_pkg::PointDepth];
  logic [31:0]        my [vwet_pkg::PointDepth];
  logic [31:0]        mz [vwet_pkg::PointDepth];
  logic [31:0]        rx_q, ry_q, rz_q;
  logic               wr;
  logic [Aw-1:0]      wr_addr;

  function automatic logic close(input logic [31:0] a, input logic [31:0] b,
                                 input logic [15:0] t);
    logic signed [32:0] d;
    logic [32:0] m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 33'(-d) : 33'(d);
    return m <= {17'd0, t};
  endfunction

  logic hit;
  assign hit = close(item_q.coord_x, rx_q, tol_i) && close(item_q.coord_y, ry_q, tol_i) &&
               close(item_q.coord_z, rz_q, tol_i);

  assign in_ready_o = (state_q == S_IDLE) && !(in_valid_i && in_data_i.kind && !job_ready_i);
  assign wr      = (state_q == S_READ) && (scan_q >= count_q);
  assign wr_addr = (count_q < Cw'(vwet_pkg::PointDepth)) ? count_q[Aw-1:0] : Last[Aw-1:0];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mx[wr_addr] <= item_q.coord_x;
      my[wr_addr] <= item_q.coord_y;
      mz[wr_addr] <= item_q.coord_z;
    end
    rx_q <= mx[scan_q[Aw-1:0]];
    ry_q <= my[scan_q[Aw-1:0]];
    rz_q <= mz[scan_q[Aw-1:0]];
  end

  always_comb begin
    job_valid_o = 1'b0;
    job_o = '0;
    job_o.pt = p_q;
    job_o.face = item_q.face_id;
    job_o.pfull = pfull_q;
    unique case (state_q)
      S_IDLE: begin
        job_valid_o = in_valid_i && in_data_i.kind;
        job_o.clear = 1'b1;
      end
      S_JOB1: begin
        job_valid_o = 1'b1;
        job_o.p1 = inside_q ? prev_q : p_q;
        job_o.p2 = p_q;
        job_o.edge_valid = inside_q || item_q.face_end;
        job_o.last = !inside_q || !item_q.face_end;
      end
      S_JOB2: begin
        job_valid_o = 1'b1;
        job_o.p1 = p_q;
        job_o.p2 = first_q;
        job_o.edge_valid = 1'b1;
        job_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      scan_q <= '0;
      first_q <= '0;
      prev_q <= '0;
      p_q <= '0;
      inside_q <= 1'b0;
      pfull_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            if (in_data_i.kind) begin
              count_q <= '0;
              inside_q <= 1'b0;
            end else begin
              item_q <= in_data_i;
              scan_q <= '0;
              pfull_q <= 1'b0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          if (wr) begin
            if (count_q < Last) begin
              p_q <= count_q[Aw-1:0];
              count_q <= count_q + 1'b1;
            end else begin
              p_q <= Aw'(count_q - 1'b1);
              pfull_q <= 1'b1;
            end
            state_q <= S_JOB1;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            p_q <= scan_q[Aw-1:0];
            state_q <= S_JOB1;
          end else begin
            scan_q <= scan_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_JOB1: begin
          if (job_ready_i) begin
            if (!inside_q) first_q <= p_q;
            prev_q <= p_q;
            if (inside_q && item_q.face_end) begin
              state_q <= S_JOB2;
            end else begin
              inside_q <= !item_q.face_end;
              state_q <= S_IDLE;
            end
          end
        end
        S_JOB2: begin
          if (job_ready_i) begin
            inside_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Last) else $error("point count overflow");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (scan_q < count_q)) else $error("scan past count");
  a_job2_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JOB2) |-> item_q.face_end) else $error("closing edge without face end");
`endif

endmodule

FILE: rtl/core/vwet_queue.sv
// ----------------------------------------------------------------------------
// vwet_queue
// Short FIFO of edge jobs between front and back.
// ----------------------------------------------------------------------------
module vwet_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  vwet_pkg::edge_job_t push_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output vwet_pkg::edge_job_t pop_o
);

  localparam int unsigned Aw = $clog2(vwet_pkg::QueueDepth);

  vwet_pkg::edge_job_t mem_q [vwet_pkg::QueueDepth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q < (Aw+1)'(vwet_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_o        = mem_q[rp_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

FILE: rtl/core/vwet_back.sv
// ----------------------------------------------------------------------------
// vwet_back
// Matches reversed edges in the edge table by linear scan; drives results.
// ----------------------------------------------------------------------------
module vwet_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  vwet_pkg::edge_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vwet_pkg::out_item_t out_data_o
);

  localparam int unsigned Aw = vwet_pkg::EdgeAw;
  localparam int unsigned Pw = vwet_pkg::PointAw;
  localparam int unsigned Cw = Aw + 1;
  localparam logic [Cw-1:0] Last = Cw'(vwet_pkg::EdgeDepth - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_OUT} state_e;

  state_e              state_q;
  vwet_pkg::edge_job_t job_q;
  logic [Cw-1:0]       count_q, scan_q;
  logic [Pw-1:0]       ms [vwet_pkg::EdgeDepth];
  logic [Pw-1:0]       me [vwet_pkg::EdgeDepth];
  logic [15:0]         ma [vwet_pkg::EdgeDepth];
  logic [15:0]         mb [vwet_pkg::EdgeDepth];
  logic [Pw-1:0]       rs_q, re_q;
  logic                wr, hit;
  logic [Aw-1:0]       wr_addr;
  vwet_pkg::out_item_t res_q;
  logic                res_valid_q;
  logic                res_set;

  assign hit = (rs_q == job_q.p2) && (re_q == job_q.p1);
  assign wr = (state_q == S_READ) && (scan_q >= count_q);
  assign wr_addr = (count_q < Cw'(vwet_pkg::EdgeDepth)) ? count_q[Aw-1:0] : Last[Aw-1:0];
  assign job_ready_o = (state_q == S_IDLE) && !(res_valid_q && !out_ready_i);
  assign out_valid_o = res_valid_q;
  assign out_data_o = res_q;
  assign res_set = ((state_q == S_IDLE) && job_valid_i && job_ready_o && !job_i.clear &&
                    !job_i.edge_valid) || (state_q == S_OUT);

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ms[wr_addr] <= job_q.p1;
      me[wr_addr] <= job_q.p2;
      ma[wr_addr] <= job_q.face;
    end
    if (state_q == S_CMP && hit) mb[scan_q[Aw-1:0]] <= job_q.face;
    rs_q <= ms[scan_q[Aw-1:0]];
    re_q <= me[scan_q[Aw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      scan_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_set) res_valid_q <= 1'b1;
      else if (res_valid_q && out_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i && job_ready_o) begin
            if (job_i.clear) begin
              count_q <= '0;
            end else if (!job_i.edge_valid) begin
              res_q <= '{point_index: 10'(job_i.pt), edge_valid: 1'b0, edge_index: '0,
                         edge_shared: 1'b0, table_full: job_i.pfull, last: job_i.last};
            end else begin
              job_q <= job_i;
              scan_q <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          if (wr) begin
            res_q.point_index <= 10'(job_q.pt);
            res_q.edge_valid <= 1'b1;
            res_q.edge_shared <= 1'b0;
            res_q.last <= job_q.last;
            if (count_q < Last) begin
              res_q.edge_index <= 10'(count_q);
              res_q.table_full <= job_q.pfull;
              count_q <= count_q + 1'b1;
            end else begin
              res_q.edge_index <= 10'(count_q - 1'b1);
              res_q.table_full <= 1'b1;
            end
            state_q <= S_OUT;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            res_q <= '{point_index: 10'(job_q.pt), edge_valid: 1'b1,
                       edge_index: 10'(scan_q), edge_shared: 1'b1,
                       table_full: job_q.pfull, last: job_q.last};
            state_q <= S_OUT;
          end else begin
            scan_q <= scan_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Last) else $error("edge count overflow");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (scan_q < count_q)) else $error("edge scan past count");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> !res_valid_q) else $error("result overwritten");
`endif

endmodule

FILE: rtl/core/vertex_weld_edge_twin_table.sv
// ----------------------------------------------------------------------------
// vertex_weld_edge_twin_table
// Vertex welding against a point table with half-edge twin matching.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes face vertices in
// winding order, or a clear item that empties both tables. Output channel
// (out_valid_o/out_ready_i/out_data_o) gives one result per opening vertex
// and per middle vertex, two for a closing vertex (last marks the final one);
// a clear gives none. weld_tol_we_i/weld_tol_i write the weld tolerance.
// The front scans the point table for each vertex and the back scans the edge
// table for each edge; the time of both scans is set by the single read port
// of each table. A two-entry queue lets the front weld the next vertex while
// the back matches edges.
// Reset empties both tables and sets the tolerance to 25. Table contents are
// never cleared; only entries below the counts are read. When the receiver
// stalls, the held result blocks the back, the queue fills, then the front.
// ----------------------------------------------------------------------------
module vertex_weld_edge_twin_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                weld_tol_we_i,
  input  logic [15:0]         weld_tol_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vwet_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vwet_pkg::out_item_t out_data_o
);

  logic [15:0] tol_q;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  vwet_pkg::edge_job_t fj, bj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= vwet_pkg::TolReset;
    else if (weld_tol_we_i) tol_q <= weld_tol_i;
  end

  vwet_front u_front (
    .clk_i, .rst_ni, .tol_i(tol_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  vwet_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fj_valid), .push_ready_o(fj_ready), .push_i(fj),
    .pop_valid_o(bj_valid), .pop_ready_i(bj_ready), .pop_o(bj)
  );

  vwet_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

FILE: sim/vertex_weld_edge_twin_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_weld_edge_twin_table_tb
// Checks vertex welding and reversed-edge matching against a local predictor.
// ----------------------------------------------------------------------------
// A short table of directed items, some with typed-in results, is followed by
// random face windings. The stimulus mixes welds within tolerance, shared edges,
// clears and tolerance changes. Both channels idle at random. The receiver
// also holds off once for a long stretch so that the block fills and stalls.
// ----------------------------------------------------------------------------
module vertex_weld_edge_twin_table_tb;

  localparam int unsigned CycleLimit = 5000000;
  localparam int unsigned DrainCycles = 4096;
  localparam int unsigned StallLen = 3000;
  localparam logic KindVertex = 1'b0;
  localparam logic KindClear = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic weld_tol_we_i = 1'b0;
  logic [15:0] weld_tol_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vwet_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  vwet_pkg::out_item_t out_data_o;

  vertex_weld_edge_twin_table dut (
    .clk_i, .rst_ni, .weld_tol_we_i, .weld_tol_i, .in_valid_i, .in_ready_o,
    .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] pt_x[vwet_pkg::PointDepth];
  logic signed [31:0] pt_y[vwet_pkg::PointDepth];
  logic signed [31:0] pt_z[vwet_pkg::PointDepth];
  int unsigned pt_count;
  logic [9:0] ed_start[vwet_pkg::EdgeDepth];
  logic [9:0] ed_end[vwet_pkg::EdgeDepth];
  int unsigned ed_count;
  logic [9:0] first_pt, prev_pt;
  bit in_face;
  logic [15:0] tol;

  vwet_pkg::out_item_t expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit stall_go = 1'b0;
  bit long_stall = 1'b0;

  function automatic bit axis_close(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d <= longint'(tol);
  endfunction

  function automatic logic [9:0] weld(vwet_pkg::in_item_t it, inout bit full);
    int unsigned slot;
    for (int unsigned i = 0; i < pt_count; i++) begin
      if (axis_close(it.coord_x, pt_x[i]) && axis_close(it.coord_y, pt_y[i]) &&
          axis_close(it.coord_z, pt_z[i])) return i[9:0];
    end
    slot = (pt_count < vwet_pkg::PointDepth) ? pt_count : vwet_pkg::PointDepth - 1;
    pt_x[slot] = it.coord_x;
    pt_y[slot] = it.coord_y;
    pt_z[slot] = it.coord_z;
    if (pt_count < vwet_pkg::PointDepth - 1) pt_count++;
    else full = 1'b1;
    return 10'(pt_count - 1);
  endfunction

  function automatic vwet_pkg::out_item_t twin_edge(logic [9:0] p1, logic [9:0] p2,
                                                    logic [9:0] pt, bit pfull, bit lst);
    vwet_pkg::out_item_t r;
    int unsigned slot;
    r = '0;
    r.point_index = pt;
    r.edge_valid = 1'b1;
    r.last = lst;
    r.table_full = pfull;
    for (int unsigned i = 0; i < ed_count; i++) begin
      if (ed_start[i] == p2 && ed_end[i] == p1) begin
        r.edge_index = i[9:0];
        r.edge_shared = 1'b1;
        return r;
      end
    end
    slot = (ed_count < vwet_pkg::EdgeDepth) ? ed_count : vwet_pkg::EdgeDepth - 1;
    ed_start[slot] = p1;
    ed_end[slot] = p2;
    if (ed_count < vwet_pkg::EdgeDepth - 1) ed_count++;
    else r.table_full = 1'b1;
    r.edge_index = 10'(ed_count - 1);
    return r;
  endfunction

  task automatic predict_weld(vwet_pkg::in_item_t it);
    bit pfull;
    logic [9:0] p;
    vwet_pkg::out_item_t r;
    pfull = 1'b0;
    if (it.kind == KindClear) begin
      pt_count = 0;
      ed_count = 0;
      in_face = 1'b0;
      return;
    end
    p = weld(it, pfull);
    if (!in_face) begin
      first_pt = p;
      prev_pt = p;
      in_face = 1'b1;
      if (!it.face_end) begin
        r = '0;
        r.point_index = p;
        r.table_full = pfull;
        r.last = 1'b1;
        expected_q.push_back(r);
        return;
      end
    end else begin
      expected_q.push_back(twin_edge(prev_pt, p, p, pfull, !it.face_end));
      prev_pt = p;
      if (!it.face_end) return;
    end
    expected_q.push_back(twin_edge(p, first_pt, p, pfull, 1'b1));
    in_face = 1'b0;
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // output side
  always @(posedge clk_i) begin
    vwet_pkg::out_item_t w;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'(out_data_o), 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (out_data_o.point_index != w.point_index)
          report("point_index", 32'(out_data_o.point_index), 32'(w.point_index));
        if (out_data_o.edge_valid != w.edge_valid)
          report("edge_valid", 32'(out_data_o.edge_valid), 32'(w.edge_valid));
        if (out_data_o.edge_index != w.edge_index)
          report("edge_index", 32'(out_data_o.edge_index), 32'(w.edge_index));
        if (out_data_o.edge_shared != w.edge_shared)
          report("edge_shared", 32'(out_data_o.edge_shared), 32'(w.edge_shared));
        if (out_data_o.table_full != w.table_full)
          report("table_full", 32'(out_data_o.table_full), 32'(w.table_full));
        if (out_data_o.last != w.last)
          report("last", 32'(out_data_o.last), 32'(w.last));
      end
    end
    if (long_stall) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // long receiver hold-off, counted here
  initial begin
    int unsigned n;
    n = 0;
    wait (stall_go);
    long_stall <= 1'b1;
    while (n < StallLen) begin
      @(posedge clk_i);
      n++;
    end
    long_stall <= 1'b0;
  end

  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send(vwet_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    predict_weld(it);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    int unsigned n;
    n = 0;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0 && n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_tol(logic [15:0] v);
    weld_tol_we_i <= 1'b1;
    weld_tol_i <= v;
    @(posedge clk_i);
    weld_tol_we_i <= 1'b0;
    tol = v;
    @(posedge clk_i);
  endtask

  function automatic vwet_pkg::in_item_t vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                             logic [15:0] f, logic e);
    vwet_pkg::in_item_t it;
    it.kind = KindVertex;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.face_id = f;
    it.face_end = e;
    return it;
  endfunction

  typedef struct {
    vwet_pkg::in_item_t it;
    bit typed;
    vwet_pkg::out_item_t want;
  } row_t;

  // random vertex near a small pool, so welds and shared edges happen
  logic signed [31:0] pool_x[8], pool_y[8], pool_z[8];

  function automatic vwet_pkg::in_item_t rand_vertex(logic [15:0] f, logic e);
    int unsigned k;
    vwet_pkg::in_item_t it;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 4) == 0)
      it = vtx($urandom, $urandom, $urandom, f, e);
    else
      it = vtx(pool_x[k] + $signed($urandom_range(0, 60)) - 30,
               pool_y[k] + $signed($urandom_range(0, 60)) - 30,
               pool_z[k] + $signed($urandom_range(0, 60)) - 30, f, e);
    return it;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    vwet_pkg::out_item_t w;
    vwet_pkg::in_item_t it;
    int unsigned sent, nv, next_tol;
    logic [15:0] face;
    pt_count = 0;
    ed_count = 0;
    in_face = 1'b0;
    first_pt = '0;
    prev_pt = '0;
    tol = vwet_pkg::TolReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; after reset results can be typed in
    w = '0; w.point_index = 10'd0; w.last = 1'b1;
    rows.push_back('{vtx(32'h7fffffff, 32'h80000000, 0, 16'hffff, 1'b0), 1'b1, w});
    w = '0; w.point_index = 10'd1; w.edge_valid = 1'b1; w.edge_index = 10'd0;
    w.last = 1'b1;
    rows.push_back('{vtx(32'h80000000, 32'h7fffffff, 32'hffffffff, 16'd0, 1'b0), 1'b1, w});
    w = '0; w.point_index = 10'd1; w.edge_valid = 1'b1; w.edge_index = 10'd1;
    w.edge_shared = 1'b1;
    rows.push_back('{vtx(32'h80000000 + 25, 32'h7fffffff - 25, 24, 16'd1, 1'b1), 1'b0, w});
    rows.push_back('{vtx(32'h7fffffff, 32'h80000000, 0, 16'd2, 1'b1), 1'b0, w});
    rows.push_back('{vtx(32'h7fffffe6, 32'h80000000, 0, 16'd3, 1'b0), 1'b0, w});
    rows.push_back('{vtx(32'h7fffffe6, 32'h80000000, 0, 16'd3, 1'b0), 1'b0, w});
    rows.push_back('{vtx(32'h00001000, 0, 0, 16'd3, 1'b0), 1'b0, w});
    rows.push_back('{vtx(32'h00001000, 0, 0, 16'd4, 1'b1), 1'b0, w});
    it = '0; it.kind = KindClear; it.coord_x = '1; it.face_end = 1'b1;
    rows.push_back('{it, 1'b0, w});
    rows.push_back('{vtx(5, 5, 5, 16'd7, 1'b1), 1'b0, w});
    rows.push_back('{vtx(100, 0, 0, 16'd8, 1'b0), 1'b0, w});
    rows.push_back('{vtx(0, 100, 0, 16'd8, 1'b0), 1'b0, w});
    rows.push_back('{vtx(0, 0, 100, 16'd9, 1'b1), 1'b0, w});
    rows.push_back('{vtx(100, 0, 0, 16'd10, 1'b0), 1'b0, w});
    rows.push_back('{vtx(0, 0, 100, 16'd10, 1'b0), 1'b0, w});
    rows.push_back('{vtx(0, 100, 0, 16'd10, 1'b1), 1'b0, w});

    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) begin
        // the predictor has to agree with the hand-written result
        send(r.it);
        if (expected_q[$] != r.want) report("directed row", i, i);
      end else begin
        send(r.it);
      end
      idle_gap();
    end
    drain();
    set_tol(16'd0);
    set_tol(16'hffff);

    foreach (pool_x[k]) begin
      pool_x[k] = $urandom;
      pool_y[k] = $urandom;
      pool_z[k] = $urandom;
    end
    sent = 0;
    next_tol = 69;
    face = '0;
    while (sent < 290) begin
      if (sent >= 120 && !stall_go) stall_go <= 1'b1;
      if (sent >= next_tol) begin
        next_tol += 70;
        drain();
        case ($urandom_range(0, 3))
          0: set_tol(16'd0);
          1: set_tol(16'hffff);
          2: set_tol(vwet_pkg::TolReset);
          default: set_tol(16'($urandom_range(0, 16'hffff)));
        endcase
      end
      if ($urandom_range(0, 25) == 0) begin
        it = '0; it.kind = KindClear;
        it.coord_x = $urandom; it.face_id = 16'($urandom);
        it.face_end = 1'($urandom);
        send(it);
        sent++;
        continue;
      end
      nv = $urandom_range(1, 6);
      face = ($urandom_range(0, 9) == 0) ? 16'($urandom) : face + 16'd1;
      for (int unsigned v = 0; v < nv; v++) begin
        it = rand_vertex(face, v == nv - 1);
        if ($urandom_range(0, 15) == 0) it.face_id = 16'($urandom);
        if ($urandom_range(0, 20) == 0) it.face_end = ~it.face_end;
        send(it);
        sent++;
        if ($urandom_range(0, 2) == 0) idle_gap();
      end
    end
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
